### rtl/palindrome_substring_range_counter_assert.svh
// Assertion macros shared by the palindrome substring range counter RTL
`ifndef PALINDROME_SUBSTRING_RANGE_COUNTER_ASSERT_SVH
`define PALINDROME_SUBSTRING_RANGE_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define PSRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define PSRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/psrc_pkg.sv
// Shared types and constants of the palindrome substring range counter
package psrc_pkg;

  // Field widths
  localparam int ModeW  = 2;
  localparam int CharW  = 8;
  localparam int IdxW   = 7;
  localparam int CntW   = 12;
  localparam int StatW  = 2;

  // Default string capacity
  localparam int MaxLenDefault = 64;

  // Item modes
  localparam logic [ModeW-1:0] ModeAppend = 2'd0;
  localparam logic [ModeW-1:0] ModeQuery  = 2'd1;
  localparam logic [ModeW-1:0] ModeClear  = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatBadRange = 2'd1;
  localparam logic [StatW-1:0] StatFull     = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_WLAST,
    ST_QRD,
    ST_RESP
  } state_e;

endpackage

### rtl/palindrome_substring_range_counter.sv
// Palindrome substring range counter: string store, count table and column-fill sequencer
//
// Holds a string of up to MAX_LEN bytes and, for every span l..r, the number of
// palindromic substrings inside it (modulo 4096). Append, query and clear words
// each give exactly one result word. A query reads the count table, stages the
// result and then loads the output register; an append fills the new column of
// the count table one left position per cycle through the single read port of
// the count memory. Clear, full-store and bad range words go straight to the
// result stage. One word is worked on at a time; a finished result waits in
// the output register while the next word is taken in. No clearing pass is
// needed after reset.
module palindrome_substring_range_counter #(
  parameter int MAX_LEN = psrc_pkg::MaxLenDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [psrc_pkg::ModeW-1:0] mode_i,
  input  logic [psrc_pkg::CharW-1:0] char_value_i,
  input  logic [psrc_pkg::IdxW-1:0]  left_index_i,
  input  logic [psrc_pkg::IdxW-1:0]  right_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [psrc_pkg::CntW-1:0]  pal_count_o,
  output logic [psrc_pkg::StatW-1:0] status_o
);

`include "palindrome_substring_range_counter_assert.svh"

  localparam int IW    = $clog2(MAX_LEN);
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int CW    = (LW > psrc_pkg::IdxW) ? LW : psrc_pkg::IdxW;
  localparam int DEPTH = 1 << (2 * IW);
  localparam int CntW  = psrc_pkg::CntW;

  // Memories
  logic [psrc_pkg::CharW-1:0] char_mem [MAX_LEN];
  logic                       pal_mem  [MAX_LEN];
  logic [CntW-1:0]            cnt_mem  [DEPTH];

  psrc_pkg::state_e state_q, state_d;

  logic [LW-1:0]               len_q;
  logic [IW-1:0]               col_q;
  logic [IW-1:0]               pos_q;
  logic [IW-1:0]               s1_pos_q;
  logic                        s1_vld_q;
  logic [psrc_pkg::CharW-1:0]  ch_q;

  logic [psrc_pkg::CharW-1:0]  char_rd_q;
  logic                        pal_rd_q;
  logic [CntW-1:0]             cnt_rd_q;
  logic                        pal_up_q;
  logic [CntW-1:0]             cnt_diag_q;
  logic [CntW-1:0]             cnt_below_q;

  logic [CntW-1:0]             res_cnt_q;
  logic [psrc_pkg::StatW-1:0]  res_st_q;
  logic                        out_valid_q;
  logic [CntW-1:0]             out_cnt_q;
  logic [psrc_pkg::StatW-1:0]  out_st_q;

  logic            accept;
  logic            walking;
  logic            out_free;
  logic            full;
  logic [CW-1:0]   left_ext, right_ext, len_ext;
  logic [CW-1:0]   left_m1, right_m1;
  logic            q_ok;
  logic [2*IW-1:0] q_addr;
  logic [2*IW-1:0] rd_addr;
  logic [IW-1:0]   col_prev;
  logic            same;
  logic            fresh;
  logic [CntW-1:0] cnt_new;

  // Input decode
  always_comb begin
    left_ext  = CW'(left_index_i);
    right_ext = CW'(right_index_i);
    len_ext   = CW'(len_q);
    left_m1   = left_ext - CW'(1);
    right_m1  = right_ext - CW'(1);
    q_ok      = (left_ext != '0) && (left_ext <= right_ext) && (right_ext <= len_ext);
    q_addr    = {left_m1[IW-1:0], right_m1[IW-1:0]};
    full      = (len_q == LW'(MAX_LEN));
    col_prev  = col_q - IW'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psrc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority if (mode_i == psrc_pkg::ModeAppend) begin
            state_d = full ? psrc_pkg::ST_RESP : psrc_pkg::ST_WALK;
          end else if (mode_i == psrc_pkg::ModeQuery) begin
            state_d = q_ok ? psrc_pkg::ST_QRD : psrc_pkg::ST_RESP;
          end else begin
            state_d = psrc_pkg::ST_RESP;
          end
        end
      end
      psrc_pkg::ST_WALK: begin
        if (pos_q == '0) state_d = psrc_pkg::ST_WLAST;
      end
      psrc_pkg::ST_WLAST: state_d = psrc_pkg::ST_RESP;
      psrc_pkg::ST_QRD:   state_d = psrc_pkg::ST_RESP;
      psrc_pkg::ST_RESP: begin
        if (out_free) state_d = psrc_pkg::ST_IDLE;
      end
      default: state_d = psrc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = (state_q == psrc_pkg::ST_IDLE);
    walking    = (state_q == psrc_pkg::ST_WALK);
    accept     = in_valid_i && in_ready_o;
    out_free   = !out_valid_q || out_ready_i;
    rd_addr    = walking ? {pos_q, col_prev} : q_addr;
  end

  // Column fill: flag and count for left position s1_pos_q
  always_comb begin
    same = (char_rd_q == ch_q);
    priority if (s1_pos_q == col_q) begin
      fresh   = 1'b1;
      cnt_new = CntW'(1);
    end else if (s1_pos_q + IW'(1) == col_q) begin
      fresh   = same;
      cnt_new = CntW'(2) + CntW'(same);
    end else begin
      fresh   = same && pal_up_q;
      cnt_new = cnt_rd_q + cnt_below_q - cnt_diag_q + CntW'(fresh);
    end
  end

  // Character store
  always_ff @(posedge clk_i) begin
    if (accept && mode_i == psrc_pkg::ModeAppend && !full) begin
      char_mem[len_q[IW-1:0]] <= char_value_i;
    end
    char_rd_q <= char_mem[pos_q];
  end

  // Palindrome flags of the last column, updated in place
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      pal_mem[s1_pos_q] <= fresh;
    end
    pal_rd_q <= pal_mem[pos_q];
  end

  // Count table
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      cnt_mem[{s1_pos_q, col_q}] <= cnt_new;
    end
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  // Walk pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= char_value_i;
      col_q <= len_q[IW-1:0];
      pos_q <= len_q[IW-1:0];
    end else if (walking) begin
      pos_q <= pos_q - IW'(1);
    end
    s1_pos_q <= pos_q;
    if (s1_vld_q) begin
      pal_up_q    <= pal_rd_q;
      cnt_diag_q  <= cnt_rd_q;
      cnt_below_q <= cnt_new;
    end
  end

  // Result staging
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_cnt_q <= '0;
      priority if (mode_i == psrc_pkg::ModeAppend) begin
        res_st_q <= full ? psrc_pkg::StatFull : psrc_pkg::StatOk;
      end else if (mode_i == psrc_pkg::ModeQuery) begin
        res_st_q <= q_ok ? psrc_pkg::StatOk : psrc_pkg::StatBadRange;
      end else begin
        res_st_q <= psrc_pkg::StatOk;
      end
    end else if (state_q == psrc_pkg::ST_QRD) begin
      res_cnt_q <= cnt_rd_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= psrc_pkg::ST_IDLE;
      len_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= walking;
      if (accept && mode_i == psrc_pkg::ModeClear) begin
        len_q <= '0;
      end else if (state_q == psrc_pkg::ST_WLAST) begin
        len_q <= len_q + LW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == psrc_pkg::ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == psrc_pkg::ST_RESP && out_free) begin
      out_cnt_q <= res_cnt_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pal_count_o = out_cnt_q;
  assign status_o    = out_st_q;

  // Checks
  `PSRC_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LW'(MAX_LEN), "string length beyond capacity")
  `PSRC_ASSERT_NXT(a_walk_end, walking && pos_q == '0, state_q == psrc_pkg::ST_WLAST, "walk did not end at position one")
  `PSRC_ASSERT_NXT(a_len_inc, state_q == psrc_pkg::ST_WLAST, len_q == $past(len_q) + LW'(1), "append did not grow the string")
  `PSRC_ASSERT_IMP(a_fill_in_walk, s1_vld_q, state_q == psrc_pkg::ST_WALK || state_q == psrc_pkg::ST_WLAST, "table write outside a walk")

endmodule
